// ----- rtl/touch_press_release_debouncer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Touch debouncer assertion macros
// Concurrent assertion wrappers shared by the debouncer RTL files.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PRESS_RELEASE_DEBOUNCER_UNIT_ASSERT_SVH
`define TOUCH_PRESS_RELEASE_DEBOUNCER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Assert a property on an explicit clock and active-low reset
`define TPD_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("touch debouncer assertion failed");
// Assert a property on the block clock and reset
`define TPD_ASSERT(lbl, prop) `TPD_ASSERT_CR(lbl, clk_i, rst_ni, prop)
`else
`define TPD_ASSERT_CR(lbl, clk, rstn, prop)
`define TPD_ASSERT(lbl, prop)
`endif

`endif

// ----- rtl/tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch debouncer package
// Types and constants shared by the touch press/release debouncer.
// ----------------------------------------------------------------------------
package tpd_pkg;

  // Debounce phases
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CAND    = 2'd1,
    PH_PRESSED = 2'd2,
    PH_RELCAND = 2'd3
  } phase_e;

  // Reported events
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_HOLD    = 2'd2,
    EV_RELEASE = 2'd3
  } event_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_PRESS_MS        = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_MS      = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_SAMPLES = 8'd2;

  // Configuration reset values
  localparam logic [15:0] PRESS_MS_RST        = 16'd30;
  localparam logic [15:0] RELEASE_MS_RST      = 16'd50;
  localparam logic [7:0]  RELEASE_SAMPLES_RST = 8'd2;

  // Saturation limit of the inactive sample counter
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [15:0] press_ms;
    logic [15:0] release_ms;
    logic [7:0]  release_samples;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  size;
  } touch_t;

  typedef struct packed {
    logic        mode;
    touch_t      touch;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    event_e      ev;
    phase_e      phase;
    touch_t      held;
    logic [31:0] hold_ms;
  } result_t;

endpackage

// ----- rtl/tpd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Touch debouncer configuration registers
// Holds the press and release timing thresholds written over the config port.
// ----------------------------------------------------------------------------
module tpd_cfg_regs
  import tpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [15:0]        wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_PRESS_MS:        cfg_d.press_ms        = wr_data_i;
        REG_RELEASE_MS:      cfg_d.release_ms      = wr_data_i;
        REG_RELEASE_SAMPLES: cfg_d.release_samples = wr_data_i[7:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_ms        <= PRESS_MS_RST;
      cfg_q.release_ms      <= RELEASE_MS_RST;
      cfg_q.release_samples <= RELEASE_SAMPLES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/tpd_core.sv -----
// ----------------------------------------------------------------------------
// Touch debouncer core
// Debounce state machine with its timestamps, sample counter and latched
// touch; updates once per stepped sample and forms the matching result.
// ----------------------------------------------------------------------------
`include "touch_press_release_debouncer_unit_assert.svh"

module tpd_core
  import tpd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  sample_t sample_i,
  output result_t result_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] cand_time_q, cand_time_d;
  logic [31:0] conf_time_q, conf_time_d;
  logic [31:0] rel_time_q, rel_time_d;
  logic [7:0]  rel_cnt_q, rel_cnt_d;
  touch_t      latch_q, latch_d;

  logic        active;
  logic [31:0] now;
  logic [31:0] cand_elapsed;
  logic [31:0] rel_elapsed;
  logic        press_due;
  logic        press_zero;
  logic [7:0]  cnt_inc;
  logic        release_due;
  logic        do_clear;

  assign active = sample_i.touch.active;
  assign now    = sample_i.now_ms;

  // Elapsed times wrap modulo 2^32
  assign cand_elapsed = now - cand_time_q;
  assign rel_elapsed  = now - rel_time_q;
  assign press_zero   = (cfg_i.press_ms == 16'd0);
  assign press_due    = (cand_elapsed >= {16'd0, cfg_i.press_ms});

  // Saturating inactive count and release test
  assign cnt_inc     = (rel_cnt_q != COUNT_MAX) ? rel_cnt_q + 8'd1 : rel_cnt_q;
  assign release_due = (cnt_inc >= cfg_i.release_samples) &&
                       (rel_elapsed >= {16'd0, cfg_i.release_ms});

  // Next state
  always_comb begin
    phase_d     = phase_q;
    cand_time_d = cand_time_q;
    conf_time_d = conf_time_q;
    rel_time_d  = rel_time_q;
    rel_cnt_d   = rel_cnt_q;
    latch_d     = latch_q;
    do_clear    = 1'b0;
    if (sample_i.mode) begin
      do_clear = 1'b1;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (active) begin
            latch_d     = sample_i.touch;
            cand_time_d = now;
            phase_d     = PH_CAND;
            if (press_zero) begin
              phase_d     = PH_PRESSED;
              conf_time_d = now;
              rel_time_d  = 32'd0;
              rel_cnt_d   = 8'd0;
            end
          end
        end
        PH_CAND: begin
          if (!active) begin
            do_clear = 1'b1;
          end else if (press_due) begin
            latch_d     = sample_i.touch;
            phase_d     = PH_PRESSED;
            conf_time_d = now;
            rel_time_d  = 32'd0;
            rel_cnt_d   = 8'd0;
          end
        end
        PH_PRESSED: begin
          if (active) begin
            latch_d = sample_i.touch;
          end else begin
            phase_d    = PH_RELCAND;
            rel_time_d = now;
            rel_cnt_d  = 8'd1;
          end
        end
        PH_RELCAND: begin
          if (active) begin
            latch_d    = sample_i.touch;
            phase_d    = PH_PRESSED;
            rel_time_d = 32'd0;
            rel_cnt_d  = 8'd0;
          end else begin
            rel_cnt_d = cnt_inc;
            if (release_due) begin
              do_clear = 1'b1;
            end
          end
        end
        default: do_clear = 1'b1;
      endcase
    end
    // Return all state to its reset value
    if (do_clear) begin
      phase_d     = PH_IDLE;
      cand_time_d = 32'd0;
      conf_time_d = 32'd0;
      rel_time_d  = 32'd0;
      rel_cnt_d   = 8'd0;
      latch_d     = '0;
    end
  end

  // Result outputs
  always_comb begin
    result_o.ev = EV_NONE;
    if (!sample_i.mode) begin
      unique case (phase_q)
        PH_IDLE:    if (active && press_zero) result_o.ev = EV_PRESS;
        PH_CAND:    if (active && press_due) result_o.ev = EV_PRESS;
        PH_PRESSED: if (active) result_o.ev = EV_HOLD;
        PH_RELCAND: begin
          if (active) begin
            result_o.ev = EV_HOLD;
          end else if (release_due) begin
            result_o.ev = EV_RELEASE;
          end
        end
        default:    result_o.ev = EV_NONE;
      endcase
    end
    result_o.phase   = phase_d;
    result_o.held    = latch_d;
    result_o.hold_ms = ((phase_d == PH_PRESSED) || (phase_d == PH_RELCAND)) ?
                       (now - conf_time_d) : 32'd0;
  end

  // Advance state on each stepped sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cand_time_q <= 32'd0;
      conf_time_q <= 32'd0;
      rel_time_q  <= 32'd0;
      rel_cnt_q   <= 8'd0;
      latch_q     <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      cand_time_q <= cand_time_d;
      conf_time_q <= conf_time_d;
      rel_time_q  <= rel_time_d;
      rel_cnt_q   <= rel_cnt_d;
      latch_q     <= latch_d;
    end
  end

  `TPD_ASSERT(a_idle_clean, (phase_q == PH_IDLE) |-> (rel_cnt_q == 8'd0 && !latch_q.active))
  `TPD_ASSERT(a_busy_latched, (phase_q != PH_IDLE) |-> latch_q.active)
  `TPD_ASSERT(a_relcand_count, (phase_q == PH_RELCAND) |-> (rel_cnt_q != 8'd0))
  `TPD_ASSERT(a_pressed_count, (phase_q == PH_PRESSED) |-> (rel_cnt_q == 8'd0))

endmodule

// ----- rtl/touch_press_release_debouncer_unit.sv -----
// ----------------------------------------------------------------------------
// Touch press/release debouncer
// Turns raw touch samples into press, hold and release events.
// ----------------------------------------------------------------------------
// Takes one touch sample per clock cycle while the result side accepts. A
// sample is transferred into an input register, the debounce state machine
// updates from it once the output register is free, and its result lands in
// the output register. A stalled output holds the input register and then
// the input side. Configuration writes are taken in any cycle and land in
// the configuration registers in the cycle after the write.
`include "touch_press_release_debouncer_unit_assert.svh"

module touch_press_release_debouncer_unit
  import tpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Sample channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic               touch_active_i,
  input  logic [7:0]         touch_id_i,
  input  logic [15:0]        touch_x_i,
  input  logic [15:0]        touch_y_i,
  input  logic [7:0]         touch_size_i,
  input  logic [31:0]        now_ms_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_code_o,
  output logic [1:0]         fsm_state_o,
  output logic               held_active_o,
  output logic [7:0]         held_id_o,
  output logic [15:0]        held_x_o,
  output logic [15:0]        held_y_o,
  output logic [7:0]         held_size_o,
  output logic [31:0]        hold_time_ms_o,
  // Configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cfg_t    cfg;
  sample_t in_sample;
  sample_t s1_q;
  logic    s1_valid_q, s1_valid_d;
  result_t res_d, res_q;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    step;
  logic    in_xfer;

  // Configuration register file
  assign cfg_ready_o = 1'b1;

  tpd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Pipeline handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_sample.mode         = mode_i;
  assign in_sample.touch.active = touch_active_i;
  assign in_sample.touch.id     = touch_id_i;
  assign in_sample.touch.x      = touch_x_i;
  assign in_sample.touch.y      = touch_y_i;
  assign in_sample.touch.size   = touch_size_i;
  assign in_sample.now_ms       = now_ms_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_sample;
    end
  end

  // Debounce state update
  tpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .sample_i (s1_q),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_code_o   = res_q.ev;
  assign fsm_state_o    = res_q.phase;
  assign held_active_o  = res_q.held.active;
  assign held_id_o      = res_q.held.id;
  assign held_x_o       = res_q.held.x;
  assign held_y_o       = res_q.held.y;
  assign held_size_o    = res_q.held.size;
  assign hold_time_ms_o = res_q.hold_ms;

  `TPD_ASSERT(a_press_state,
              (out_valid_q && (res_q.ev == EV_PRESS || res_q.ev == EV_HOLD)) |->
              (res_q.phase == PH_PRESSED))
  `TPD_ASSERT(a_release_state,
              (out_valid_q && res_q.ev == EV_RELEASE) |-> (res_q.phase == PH_IDLE))
  `TPD_ASSERT(a_hold_zero,
              (out_valid_q && (res_q.phase == PH_IDLE || res_q.phase == PH_CAND)) |->
              (res_q.hold_ms == 32'd0))

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Touch press/release debouncer testbench
// Drives touch samples and register writes into the debouncer, predicts every
// result with a cycle-free copy of the debounce state machine and compares
// each result field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpd_pkg::*;

  // Register indexes outside the mapped range
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED  = 8'd3;
  localparam logic [CfgIdxW-1:0] REG_TOP_INDEX = 8'hFF;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        mode_i         = 1'b0;
  logic        touch_active_i = 1'b0;
  logic [7:0]  touch_id_i     = '0;
  logic [15:0] touch_x_i      = '0;
  logic [15:0] touch_y_i      = '0;
  logic [7:0]  touch_size_i   = '0;
  logic [31:0] now_ms_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  event_code_o;
  logic [1:0]  fsm_state_o;
  logic        held_active_o;
  logic [7:0]  held_id_o;
  logic [15:0] held_x_o;
  logic [15:0] held_y_o;
  logic [7:0]  held_size_o;
  logic [31:0] hold_time_ms_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0]        cfg_data_i  = '0;

  touch_press_release_debouncer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .touch_active_i (touch_active_i),
    .touch_id_i     (touch_id_i),
    .touch_x_i      (touch_x_i),
    .touch_y_i      (touch_y_i),
    .touch_size_i   (touch_size_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_code_o   (event_code_o),
    .fsm_state_o    (fsm_state_o),
    .held_active_o  (held_active_o),
    .held_id_o      (held_id_o),
    .held_x_o       (held_x_o),
    .held_y_o       (held_y_o),
    .held_size_o    (held_size_o),
    .hold_time_ms_o (hold_time_ms_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Tracked copy of the debouncer state and its registers
  cfg_t        dbn_cfg;
  phase_e      trk_phase;
  logic [31:0] trk_cand_ms;
  logic [31:0] trk_confirm_ms;
  logic [31:0] trk_relcand_ms;
  logic [7:0]  trk_rel_count;
  touch_t      trk_touch;

  // Results still owed by the block, oldest first
  result_t     pending_reports[$];

  logic [31:0] clock_ms       = '0;
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;
  int unsigned rx_hold_left   = 0;
  int unsigned samples_sent   = 0;
  int unsigned cfg_writes     = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned event_seen [4] = '{default: 0};

  // Generate the clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Drop all tracked state back to idle
  function automatic void clear_tracker();
    trk_phase      = PH_IDLE;
    trk_cand_ms    = '0;
    trk_confirm_ms = '0;
    trk_relcand_ms = '0;
    trk_rel_count  = '0;
    trk_touch      = '0;
  endfunction

  function automatic void confirm_press(input logic [31:0] now);
    trk_phase      = PH_PRESSED;
    trk_confirm_ms = now;
    trk_relcand_ms = '0;
    trk_rel_count  = '0;
  endfunction

  // Advance the tracked state by one sample and return the result it causes
  function automatic result_t debounce_step(input sample_t s);
    result_t     r;
    logic [31:0] since;
    r.ev = EV_NONE;
    if (s.mode) begin
      clear_tracker();
    end else begin
      case (trk_phase)
        PH_IDLE: begin
          if (s.touch.active) begin
            trk_touch   = s.touch;
            trk_cand_ms = s.now_ms;
            trk_phase   = PH_CAND;
            if (dbn_cfg.press_ms == 16'd0) begin
              confirm_press(s.now_ms);
              r.ev = EV_PRESS;
            end
          end
        end
        PH_CAND: begin
          since = s.now_ms - trk_cand_ms;
          if (!s.touch.active) begin
            clear_tracker();
          end else if (since >= {16'd0, dbn_cfg.press_ms}) begin
            trk_touch = s.touch;
            confirm_press(s.now_ms);
            r.ev = EV_PRESS;
          end
        end
        PH_PRESSED: begin
          if (s.touch.active) begin
            trk_touch = s.touch;
            r.ev = EV_HOLD;
          end else begin
            trk_phase      = PH_RELCAND;
            trk_relcand_ms = s.now_ms;
            trk_rel_count  = 8'd1;
          end
        end
        default: begin
          if (s.touch.active) begin
            trk_touch      = s.touch;
            trk_phase      = PH_PRESSED;
            trk_relcand_ms = '0;
            trk_rel_count  = '0;
            r.ev = EV_HOLD;
          end else begin
            // Saturate the inactive count, then test both release limits
            if (trk_rel_count != COUNT_MAX) trk_rel_count = trk_rel_count + 8'd1;
            since = s.now_ms - trk_relcand_ms;
            if (trk_rel_count >= dbn_cfg.release_samples &&
                since >= {16'd0, dbn_cfg.release_ms}) begin
              clear_tracker();
              r.ev = EV_RELEASE;
            end
          end
        end
      endcase
    end
    r.phase   = trk_phase;
    r.held    = trk_touch;
    r.hold_ms = (trk_phase == PH_PRESSED || trk_phase == PH_RELCAND) ?
                s.now_ms - trk_confirm_ms : 32'd0;
    return r;
  endfunction

  // Build a sample with random touch content
  function automatic sample_t touch_sample(input logic mode, input logic active,
                                           input logic [31:0] now);
    sample_t s;
    s.mode         = mode;
    s.touch.active = active;
    s.touch.id     = 8'($urandom());
    s.touch.x      = 16'($urandom());
    s.touch.y      = 16'($urandom());
    s.touch.size   = 8'($urandom());
    s.now_ms       = now;
    return s;
  endfunction

  // Step the sample clock forward, now and then jumping anywhere
  function automatic void advance_clock(input logic [15:0] span);
    if ($urandom_range(24) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(32'(span) / 2 + 2);
  endfunction

  // Offer one sample, hold it until the transfer, and record its result
  task automatic send_sample(input sample_t s);
    if (!tx_steady) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    mode_i         <= s.mode;
    touch_active_i <= s.touch.active;
    touch_id_i     <= s.touch.id;
    touch_x_i      <= s.touch.x;
    touch_y_i      <= s.touch.y;
    touch_size_i   <= s.touch.size;
    now_ms_i       <= s.now_ms;
    do @(posedge clk_i); while (!in_ready_o);
    pending_reports.push_back(debounce_step(s));
    samples_sent++;
  endtask

  // Stop offering samples and wait for every owed result
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; the block must be idle
  task automatic cfg_write(input logic [CfgIdxW-1:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_PRESS_MS:        dbn_cfg.press_ms        = data;
      REG_RELEASE_MS:      dbn_cfg.release_ms      = data;
      REG_RELEASE_SAMPLES: dbn_cfg.release_samples = data[7:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] press_ms, input logic [15:0] release_ms,
                                input logic [15:0] release_samples);
    cfg_write(REG_PRESS_MS, press_ms);
    cfg_write(REG_RELEASE_MS, release_ms);
    cfg_write(REG_RELEASE_SAMPLES, release_samples);
  endtask

  // One touch: a run of active samples, a run of inactive ones, at times a stray sample
  task automatic send_gesture();
    int unsigned n_down;
    int unsigned n_up;
    n_down = $urandom_range(10, 1);
    n_up   = $urandom_range(8, 1);
    for (int i = 0; i < n_down; i++) begin
      advance_clock(dbn_cfg.press_ms);
      send_sample(touch_sample(1'b0, 1'b1, clock_ms));
    end
    for (int i = 0; i < n_up; i++) begin
      advance_clock(dbn_cfg.release_ms);
      send_sample(touch_sample(1'b0, 1'b0, clock_ms));
    end
    if ($urandom_range(6) == 0) begin
      send_sample(touch_sample($urandom_range(3) == 0, 1'($urandom()), $urandom()));
    end
  endtask

  // Walk the state machine through every transition and field extreme
  task automatic test_directed();
    sample_t s;
    s = touch_sample(1'b0, 1'b1, 32'd100);
    s.touch = '0;
    s.touch.active = 1'b1;
    send_sample(s);
    send_sample(touch_sample(1'b0, 1'b1, 32'd110));
    s = touch_sample(1'b0, 1'b1, 32'd130);
    s.touch = '1;
    send_sample(s);
    send_sample(touch_sample(1'b0, 1'b1, 32'd140));
    send_sample(touch_sample(1'b0, 1'b0, 32'd150));
    send_sample(touch_sample(1'b0, 1'b0, 32'd170));
    send_sample(touch_sample(1'b0, 1'b0, 32'd200));
    send_sample(touch_sample(1'b0, 1'b0, 32'd210));
    // Lose the press candidate on an inactive sample
    send_sample(touch_sample(1'b0, 1'b1, 32'd220));
    send_sample(touch_sample(1'b0, 1'b0, 32'd225));
    // Clear from press candidate with every raw bit set
    send_sample(touch_sample(1'b0, 1'b1, 32'd300));
    s = touch_sample(1'b1, 1'b1, '1);
    s.touch = '1;
    send_sample(s);
    // Press across the 32-bit time wrap, then a timestamp that goes back
    send_sample(touch_sample(1'b0, 1'b1, 32'hFFFF_FFF0));
    send_sample(touch_sample(1'b0, 1'b1, 32'h0000_0010));
    send_sample(touch_sample(1'b0, 1'b0, 32'h0000_0020));
    send_sample(touch_sample(1'b0, 1'b1, 32'h0000_0030));
    send_sample(touch_sample(1'b0, 1'b0, 32'h0000_0040));
    send_sample(touch_sample(1'b0, 1'b0, 32'h0000_0010));
    send_sample(touch_sample(1'b1, 1'b0, 32'h0000_0050));
    // Zero press time confirms at once; clear from pressed and release candidate
    wait_drain();
    cfg_write(REG_PRESS_MS, 16'd0);
    cfg_write(REG_UNMAPPED, 16'hFFFF);
    cfg_write(REG_TOP_INDEX, 16'h5A5A);
    send_sample(touch_sample(1'b0, 1'b1, 32'h0000_0060));
    send_sample(touch_sample(1'b1, 1'b1, 32'h0000_0070));
    send_sample(touch_sample(1'b0, 1'b1, 32'h0000_0080));
    send_sample(touch_sample(1'b0, 1'b0, 32'h0000_0090));
    send_sample(touch_sample(1'b1, 1'b0, 32'h0000_00A0));
    wait_drain();
  endtask

  // Hold a release candidate long enough for the inactive count to saturate
  task automatic test_count_saturation();
    apply_settings(16'd0, 16'd2800, 16'd255);
    clock_ms = 32'h1000_0000;
    send_sample(touch_sample(1'b0, 1'b1, clock_ms));
    for (int i = 0; i < 285; i++) begin
      clock_ms = clock_ms + 32'd10;
      send_sample(touch_sample(1'b0, 1'b0, clock_ms));
    end
    wait_drain();
  endtask

  // Stall the result side long enough to back up the sample side
  task automatic test_backpressure();
    apply_settings(16'd5, 16'd8, 16'd2);
    tx_steady    = 1'b1;
    rx_hold_left = 200;
    for (int i = 0; i < 40; i++) begin
      advance_clock(16'd12);
      send_sample(touch_sample(1'b0, $urandom_range(3) != 0, clock_ms));
    end
    tx_steady = 1'b0;
    wait_drain();
  endtask

  // Run both channels flat out
  task automatic test_streaming();
    int unsigned base;
    apply_settings(16'd20, 16'd40, 16'd2);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    base = samples_sent;
    while (samples_sent - base < 200) send_gesture();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drain();
  endtask

  // Random gestures under a range of register settings, extremes included
  task automatic test_random_settings();
    int unsigned base;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings(16'd0, 16'd0, 16'd0);
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'd255);
        2: apply_settings(16'd10, 16'd100, 16'd3);
        3: apply_settings(16'd0, 16'hFFFF, 16'd1);
        4: apply_settings(16'hFFFF, 16'd0, 16'hFF00);
        default: begin
          apply_settings(16'($urandom_range(200)), 16'($urandom_range(300)),
                         16'($urandom_range(6)));
          cfg_write(8'($urandom_range(255, 3)), 16'($urandom()));
        end
      endcase
      base = samples_sent;
      while (samples_sent - base < 140) send_gesture();
      wait_drain();
    end
  endtask

  // Accept results: random stalls, a counted hold-off, or always ready
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (rx_hold_left != 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= rx_steady || ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s mismatch on result %0d: expected %0h, got %0h",
                 name, results_checked, want, got);
      end
    end
  endfunction

  // Compare each result transfer with the oldest owed result
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result at %0t: event %0d state %0d",
                   $realtime, event_code_o, fsm_state_o);
        end
      end else begin
        want = pending_reports.pop_front();
        results_checked++;
        event_seen[want.ev]++;
        check_field("event_code", 32'(want.ev), 32'(event_code_o));
        check_field("fsm_state", 32'(want.phase), 32'(fsm_state_o));
        check_field("held_active", 32'(want.held.active), 32'(held_active_o));
        check_field("held_id", 32'(want.held.id), 32'(held_id_o));
        check_field("held_x", 32'(want.held.x), 32'(held_x_o));
        check_field("held_y", 32'(want.held.y), 32'(held_y_o));
        check_field("held_size", 32'(want.held.size), 32'(held_size_o));
        check_field("hold_time_ms", want.hold_ms, hold_time_ms_o);
      end
    end
  end

  // Bound the run
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_reports.size());
    $display("touch_press_release_debouncer_unit test failed");
    $finish;
  end

  initial begin : test_sequence
    dbn_cfg.press_ms        = PRESS_MS_RST;
    dbn_cfg.release_ms      = RELEASE_MS_RST;
    dbn_cfg.release_samples = RELEASE_SAMPLES_RST;
    clear_tracker();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_count_saturation();
    test_backpressure();
    test_streaming();
    test_random_settings();

    // Let any stray result show up before judging
    wait_drain();
    repeat (10) @(posedge clk_i);

    $display("%0d samples sent, %0d results checked, %0d register writes",
             samples_sent, results_checked, cfg_writes);
    $display("events seen: %0d none, %0d press, %0d hold, %0d release; %0d mismatches",
             event_seen[EV_NONE], event_seen[EV_PRESS], event_seen[EV_HOLD],
             event_seen[EV_RELEASE], mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("touch_press_release_debouncer_unit test passed");
    end else begin
      $display("touch_press_release_debouncer_unit test failed");
    end
    $finish;
  end

endmodule
